// File: design/generational_slot_allocator_core_assert.svh
// Assertion macros for the generational slot allocator.
// Used by the top level; no dependencies.
`ifndef GENERATIONAL_SLOT_ALLOCATOR_CORE_ASSERT_SVH
`define GENERATIONAL_SLOT_ALLOCATOR_CORE_ASSERT_SVH

// Property that holds at every clock edge outside reset.
`define GSA_ASSERT_HOLDS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("gsa: invariant violated");

// Antecedent implies consequent, checked outside reset.
`define GSA_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gsa: implication violated");

`endif

// File: design/gsa_pkg.sv
// Package for the generational slot allocator: field widths, reset values,
// action and register codes, configuration struct. No dependencies.
`default_nettype none

package gsa_pkg;

   localparam int SLOT_COUNT_DEF = 64;

   localparam int ACT_W     = 2;
   localparam int JNT_W     = 16;
   localparam int HIDX_W    = 8;
   localparam int GEN_W     = 32;
   localparam int LIM_W     = 7;
   localparam int TALLY_W   = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [LIM_W-1:0] LIVE_LIMIT_RST   = 7'd64;
   localparam logic [JNT_W-1:0] JOINT_BUDGET_RST = 16'hFFFF;

   typedef enum logic [ACT_W-1:0] {
      ACT_CREATE  = 2'd0,
      ACT_DESTROY = 2'd1,
      ACT_RESOLVE = 2'd2,
      ACT_NONE    = 2'd3
   } gsa_action_type;

   typedef enum logic {
      REG_LIVE_LIMIT   = 1'b0,
      REG_JOINT_BUDGET = 1'b1
   } gsa_reg_type;

   typedef struct packed {
      logic [LIM_W-1:0] live_limit;
      logic [JNT_W-1:0] joint_budget;
   } gsa_cfg_type;

endpackage

`default_nettype wire

// File: design/generational_slot_allocator_core.sv
// Generational slot allocator: handle pool with per-slot generations,
// LIFO free stack, joint budget and running statistics.
// Depends on gsa_pkg, gsa_csr and generational_slot_allocator_core_assert.svh.
//
// Usage:
//   Request channel: a beat is taken at a rising edge with start high and busy
//   low. busy stays low, so a request may be issued every cycle.
//   Result channel: every request yields one result beat, marked by rsp_valid
//   for a single cycle, through the request stage and result register. The
//   receiver cannot stall; take the beat in that cycle.
//   Throughput: one request per cycle. Request fields and the slot memory reads
//   are registered at the request edge, the stage logic resolves the handle,
//   the free-stack top and the counters, and the result register follows.
//   Back-to-back requests on the same slot are forwarded around the memories.
//   Configuration: APB-style port, live limit at byte 0, joint budget at
//   byte 4; write only while no request is in flight.
//   Reset: synchronous; clears slot occupancy, generation valid bits, free
//   stack depth, counters and peaks, and restores the configuration
//   defaults. No clearing pass is needed.
`default_nettype none

module generational_slot_allocator_core #(
   parameter int SLOT_COUNT = gsa_pkg::SLOT_COUNT_DEF,
   localparam int IDX_W = $clog2(SLOT_COUNT),
   localparam int CNT_W = $clog2(SLOT_COUNT + 1)
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 start,
   output logic                                busy,
   input  wire  [gsa_pkg::ACT_W-1:0]           req_action,
   input  wire  [gsa_pkg::JNT_W-1:0]           req_joint_count,
   input  wire  [gsa_pkg::HIDX_W-1:0]          req_handle_index,
   input  wire  [gsa_pkg::GEN_W-1:0]           req_handle_generation,
   output logic                                rsp_valid,
   output logic                                rsp_accepted,
   output logic [IDX_W-1:0]                    rsp_out_index,
   output logic [gsa_pkg::GEN_W-1:0]           rsp_out_generation,
   output logic [gsa_pkg::JNT_W-1:0]           rsp_slot_joints,
   output logic [CNT_W-1:0]                    rsp_live_total,
   output logic [gsa_pkg::JNT_W-1:0]           rsp_joint_total,
   output logic [CNT_W-1:0]                    rsp_live_peak,
   output logic [gsa_pkg::JNT_W-1:0]           rsp_joint_peak,
   output logic [gsa_pkg::TALLY_W-1:0]         rsp_reject_tally,
   input  wire                                 psel,
   input  wire                                 penable,
   input  wire                                 pwrite,
   input  wire  [gsa_pkg::CSR_ADDR_W-1:0]      paddr,
   input  wire  [gsa_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [gsa_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                pready
);

`include "generational_slot_allocator_core_assert.svh"

   localparam int GEN_W = gsa_pkg::GEN_W;
   localparam int JNT_W = gsa_pkg::JNT_W;
   localparam int STK_W = IDX_W + GEN_W;
   localparam int LW    = (CNT_W > gsa_pkg::LIM_W) ? CNT_W : gsa_pkg::LIM_W;
   localparam int HW    = gsa_pkg::HIDX_W + 1;

   gsa_pkg::gsa_cfg_type cfg;

   gsa_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // slot memories
   logic [GEN_W-1:0] gen_mem [SLOT_COUNT];
   logic [JNT_W-1:0] jnt_mem [SLOT_COUNT];
   logic [STK_W-1:0] stk_mem [SLOT_COUNT];

   logic [SLOT_COUNT-1:0] gen_vld_ff;
   logic [SLOT_COUNT-1:0] gen_vld_in;
   logic [SLOT_COUNT-1:0] occ_ff;
   logic [SLOT_COUNT-1:0] occ_in;

   // request stage
   logic                         stg_vld_ff;
   gsa_pkg::gsa_action_type      stg_act_ff;
   logic [JNT_W-1:0]             stg_jc_ff;
   logic [gsa_pkg::HIDX_W-1:0]   stg_idx_ff;
   logic [GEN_W-1:0]             stg_gen_ff;

   logic [GEN_W-1:0] gen_q_ff;
   logic             gen_fwd_ff;
   logic [GEN_W-1:0] gen_fwd_dat_ff;
   logic [JNT_W-1:0] jnt_q_ff;
   logic             jnt_fwd_ff;
   logic [JNT_W-1:0] jnt_fwd_dat_ff;
   logic [STK_W-1:0] top_q_ff;
   logic             top_fwd_ff;
   logic [STK_W-1:0] top_fwd_dat_ff;

   // pool state
   logic [CNT_W-1:0]            free_depth_ff,  free_depth_in;
   logic [CNT_W-1:0]            opened_ff,      opened_in;
   logic [CNT_W-1:0]            live_ff,        live_in;
   logic [JNT_W-1:0]            joints_ff,      joints_in;
   logic [CNT_W-1:0]            live_peak_ff,   live_peak_in;
   logic [JNT_W-1:0]            joint_peak_ff,  joint_peak_in;
   logic [gsa_pkg::TALLY_W-1:0] rej_ff,         rej_in;

   // result register
   logic                        rsp_valid_ff;
   logic                        rsp_acc_ff,     rsp_acc_in;
   logic [IDX_W-1:0]            rsp_idx_ff,     rsp_idx_in;
   logic [GEN_W-1:0]            rsp_gen_ff,     rsp_gen_in;
   logic [JNT_W-1:0]            rsp_sj_ff,      rsp_sj_in;

   // memory write ports
   logic             gen_we;
   logic [IDX_W-1:0] gen_wa;
   logic [GEN_W-1:0] gen_wd;
   logic             jnt_we;
   logic [IDX_W-1:0] jnt_wa;
   logic [JNT_W-1:0] jnt_wd;
   logic             stk_we;
   logic [IDX_W-1:0] stk_wa;
   logic [STK_W-1:0] stk_wd;

   logic             req_beat;
   logic [IDX_W-1:0] req_addr;
   logic [CNT_W-1:0] stk_ra_full;
   logic [IDX_W-1:0] stk_ra;

   assign busy     = 1'b0;
   assign req_beat = start && !busy;
   assign req_addr = req_handle_index[IDX_W-1:0];

   always_comb begin
      logic [IDX_W-1:0] s_idx;
      logic             idx_ok;
      logic [GEN_W-1:0] gen_cur;
      logic [GEN_W-1:0] gen_new;
      logic [JNT_W-1:0] jnt_cur;
      logic [STK_W-1:0] top_cur;
      logic             handle_ok;
      logic             lim_ok;
      logic             bud_ok;
      logic             has_free;
      logic             can_open;
      logic [IDX_W-1:0] slot;
      logic [GEN_W-1:0] slot_gen;
      logic [gsa_pkg::TALLY_W-1:0] rej_inc;

      s_idx    = stg_idx_ff[IDX_W-1:0];
      idx_ok   = {1'b0, stg_idx_ff} < HW'(opened_ff);
      gen_cur  = gen_fwd_ff ? gen_fwd_dat_ff
                            : (gen_vld_ff[s_idx] ? gen_q_ff : GEN_W'(1));
      gen_new  = (gen_cur == '1) ? GEN_W'(1) : gen_cur + GEN_W'(1);
      jnt_cur  = jnt_fwd_ff ? jnt_fwd_dat_ff : jnt_q_ff;
      top_cur  = top_fwd_ff ? top_fwd_dat_ff : top_q_ff;
      handle_ok = (stg_gen_ff != '0) && idx_ok && (gen_cur == stg_gen_ff) && occ_ff[s_idx];
      lim_ok   = (LW'(live_ff) < LW'(cfg.live_limit)) && (live_ff < CNT_W'(SLOT_COUNT));
      bud_ok   = (stg_jc_ff != '0) && (stg_jc_ff <= cfg.joint_budget) &&
                 (joints_ff <= cfg.joint_budget - stg_jc_ff);
      has_free = free_depth_ff != '0;
      can_open = opened_ff < CNT_W'(SLOT_COUNT);
      slot     = has_free ? top_cur[STK_W-1:GEN_W] : opened_ff[IDX_W-1:0];
      slot_gen = has_free ? top_cur[GEN_W-1:0] : GEN_W'(1);
      rej_inc  = (rej_ff != '1) ? rej_ff + gsa_pkg::TALLY_W'(1) : rej_ff;

      free_depth_in = free_depth_ff;
      opened_in     = opened_ff;
      live_in       = live_ff;
      joints_in     = joints_ff;
      live_peak_in  = live_peak_ff;
      joint_peak_in = joint_peak_ff;
      rej_in        = rej_ff;
      gen_vld_in    = gen_vld_ff;
      occ_in        = occ_ff;
      rsp_acc_in    = 1'b0;
      rsp_idx_in    = '0;
      rsp_gen_in    = '0;
      rsp_sj_in     = '0;
      gen_we = 1'b0;
      gen_wa = s_idx;
      gen_wd = gen_new;
      jnt_we = 1'b0;
      jnt_wa = slot;
      jnt_wd = stg_jc_ff;
      stk_we = 1'b0;
      stk_wa = free_depth_ff[IDX_W-1:0];
      stk_wd = {s_idx, gen_new};

      if (stg_vld_ff) begin
         case (stg_act_ff)
            gsa_pkg::ACT_CREATE: begin
               if (lim_ok && bud_ok && (has_free || can_open)) begin
                  if (has_free) begin
                     free_depth_in = free_depth_ff - CNT_W'(1);
                  end else begin
                     opened_in = opened_ff + CNT_W'(1);
                  end
                  occ_in[slot] = 1'b1;
                  jnt_we       = 1'b1;
                  live_in      = live_ff + CNT_W'(1);
                  joints_in    = joints_ff + stg_jc_ff;
                  if (live_in > live_peak_ff) begin
                     live_peak_in = live_in;
                  end
                  if (joints_in > joint_peak_ff) begin
                     joint_peak_in = joints_in;
                  end
                  rsp_acc_in = 1'b1;
                  rsp_idx_in = slot;
                  rsp_gen_in = slot_gen;
                  rsp_sj_in  = stg_jc_ff;
               end else begin
                  rej_in = rej_inc;
               end
            end
            gsa_pkg::ACT_DESTROY: begin
               if (handle_ok) begin
                  rsp_sj_in = jnt_cur;
                  joints_in = (joints_ff >= jnt_cur) ? joints_ff - jnt_cur : '0;
                  if (live_ff != '0) begin
                     live_in = live_ff - CNT_W'(1);
                  end
                  occ_in[s_idx]     = 1'b0;
                  gen_vld_in[s_idx] = 1'b1;
                  gen_we            = 1'b1;
                  if (free_depth_ff < CNT_W'(SLOT_COUNT)) begin
                     stk_we        = 1'b1;
                     free_depth_in = free_depth_ff + CNT_W'(1);
                  end
                  rsp_acc_in = 1'b1;
               end else begin
                  rej_in = rej_inc;
               end
            end
            gsa_pkg::ACT_RESOLVE: begin
               if (handle_ok) begin
                  rsp_acc_in = 1'b1;
                  rsp_sj_in  = jnt_cur;
               end
            end
            default: begin
               rsp_acc_in = 1'b0;
            end
         endcase
      end
   end

   // prefetch the free-stack top for the next beat
   assign stk_ra_full = free_depth_in - CNT_W'(1);
   assign stk_ra      = stk_ra_full[IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (gen_we) begin
         gen_mem[gen_wa] <= gen_wd;
      end
      gen_q_ff <= gen_mem[req_addr];
   end

   always_ff @(posedge clock) begin
      if (jnt_we) begin
         jnt_mem[jnt_wa] <= jnt_wd;
      end
      jnt_q_ff <= jnt_mem[req_addr];
   end

   always_ff @(posedge clock) begin
      if (stk_we) begin
         stk_mem[stk_wa] <= stk_wd;
      end
      top_q_ff <= stk_mem[stk_ra];
   end

   always_ff @(posedge clock) begin
      stg_act_ff     <= gsa_pkg::gsa_action_type'(req_action);
      stg_jc_ff      <= req_joint_count;
      stg_idx_ff     <= req_handle_index;
      stg_gen_ff     <= req_handle_generation;
      gen_fwd_ff     <= gen_we && (gen_wa == req_addr);
      gen_fwd_dat_ff <= gen_wd;
      jnt_fwd_ff     <= jnt_we && (jnt_wa == req_addr);
      jnt_fwd_dat_ff <= jnt_wd;
      top_fwd_ff     <= stk_we;
      top_fwd_dat_ff <= stk_wd;
      rsp_acc_ff     <= rsp_acc_in;
      rsp_idx_ff     <= rsp_idx_in;
      rsp_gen_ff     <= rsp_gen_in;
      rsp_sj_ff      <= rsp_sj_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_vld_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         gen_vld_ff    <= '0;
         occ_ff        <= '0;
         free_depth_ff <= '0;
         opened_ff     <= '0;
         live_ff       <= '0;
         joints_ff     <= '0;
         live_peak_ff  <= '0;
         joint_peak_ff <= '0;
         rej_ff        <= '0;
      end else begin
         stg_vld_ff    <= req_beat;
         rsp_valid_ff  <= stg_vld_ff;
         gen_vld_ff    <= gen_vld_in;
         occ_ff        <= occ_in;
         free_depth_ff <= free_depth_in;
         opened_ff     <= opened_in;
         live_ff       <= live_in;
         joints_ff     <= joints_in;
         live_peak_ff  <= live_peak_in;
         joint_peak_ff <= joint_peak_in;
         rej_ff        <= rej_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_accepted       = rsp_acc_ff;
   assign rsp_out_index      = rsp_idx_ff;
   assign rsp_out_generation = rsp_gen_ff;
   assign rsp_slot_joints    = rsp_sj_ff;
   assign rsp_live_total     = live_ff;
   assign rsp_joint_total    = joints_ff;
   assign rsp_live_peak      = live_peak_ff;
   assign rsp_joint_peak     = joint_peak_ff;
   assign rsp_reject_tally   = rej_ff;

   `GSA_ASSERT_IMPLIES(a_beat_gives_result, clock, reset, req_beat, ##2 rsp_valid)
   `GSA_ASSERT_HOLDS(a_slot_conservation, clock, reset, free_depth_ff + live_ff == opened_ff)
   `GSA_ASSERT_IMPLIES(a_tally_monotonic, clock, reset, !$past(reset), rej_ff >= $past(rej_ff))
   `GSA_ASSERT_IMPLIES(a_reject_clear, clock, reset, rsp_valid_ff && !rsp_acc_ff, rsp_gen_ff == '0)

endmodule

`default_nettype wire

// File: design/gsa_csr.sv
// APB-style configuration registers: live limit and joint budget.
// Depends on gsa_pkg.
`default_nettype none

module gsa_csr (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 psel,
   input  wire                                 penable,
   input  wire                                 pwrite,
   input  wire  [gsa_pkg::CSR_ADDR_W-1:0]      paddr,
   input  wire  [gsa_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [gsa_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                pready,
   output gsa_pkg::gsa_cfg_type                cfg
);

   gsa_pkg::gsa_cfg_type cfg_ff;
   gsa_pkg::gsa_cfg_type cfg_in;
   gsa_pkg::gsa_reg_type reg_sel;
   logic                 wr_beat;

   assign reg_sel = gsa_pkg::gsa_reg_type'(paddr[gsa_pkg::CSR_ADDR_W-1]);
   assign wr_beat = psel && penable && pwrite && pready;
   assign pready  = 1'b1;
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      prdata = '0;
      case (reg_sel)
         gsa_pkg::REG_LIVE_LIMIT: begin
            prdata = gsa_pkg::CSR_DATA_W'(cfg_ff.live_limit);
            if (wr_beat) begin
               cfg_in.live_limit = pwdata[gsa_pkg::LIM_W-1:0];
            end
         end
         gsa_pkg::REG_JOINT_BUDGET: begin
            prdata = gsa_pkg::CSR_DATA_W'(cfg_ff.joint_budget);
            if (wr_beat) begin
               cfg_in.joint_budget = pwdata[gsa_pkg::JNT_W-1:0];
            end
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.live_limit   <= gsa_pkg::LIVE_LIMIT_RST;
         cfg_ff.joint_budget <= gsa_pkg::JOINT_BUDGET_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire
